@@ hdl/ddo_pkg.sv @@
// Package for the differential drive odometry grid tracker.
// Holds shared types, constants and the CORDIC arctangent table; depends on nothing.
package ddo_pkg;

    localparam int CordicSteps = 24;
    localparam int StepW = $clog2(CordicSteps + 1);
    localparam logic [31:0] Quarter = 32'h4000_0000;
    localparam logic [31:0] Half = 32'h8000_0000;
    localparam logic [31:0] GainQ32 = 32'h9B74_EDA8;

    localparam logic [2:0] RegMode = 3'd0;
    localparam logic [2:0] RegMapDir = 3'd1;
    localparam logic [2:0] RegRobotDir = 3'd2;
    localparam logic [2:0] RegMetres = 3'd3;
    localparam logic [2:0] RegTurn = 3'd4;

    localparam logic [2:0] MisWait = 3'd0;
    localparam logic [2:0] MisNext = 3'd1;
    localparam logic [2:0] MisTurn = 3'd2;
    localparam logic [2:0] MisRight90 = 3'd4;

    // Work item handed from the front end to the back end.
    typedef struct packed {
        logic        prime;
        logic        step;
        logic [2:0]  dir;
        logic [2:0]  mission;
        logic        mode;
        logic [31:0] dl;
        logic [31:0] dr;
        logic [23:0] mpt;
        logic [23:0] tpt;
    } t_work;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_TRAV, S_GAIN, S_ITER, S_DONE
    } t_state;

    function automatic logic [31:0] atan_of(input logic [4:0] i);
        logic [31:0] t;
        case (i)
            5'd0: t = 32'h20000000;  5'd1: t = 32'h12E4051E;  5'd2: t = 32'h09FB385B;
            5'd3: t = 32'h051111D4;  5'd4: t = 32'h028B0D43;  5'd5: t = 32'h0145D7E1;
            5'd6: t = 32'h00A2F61E;  5'd7: t = 32'h00517C55;  5'd8: t = 32'h0028BE53;
            5'd9: t = 32'h00145F2F;  5'd10: t = 32'h000A2F98; 5'd11: t = 32'h000517CC;
            5'd12: t = 32'h00028BE6; 5'd13: t = 32'h000145F3; 5'd14: t = 32'h0000A2FA;
            5'd15: t = 32'h0000517D; 5'd16: t = 32'h000028BE; 5'd17: t = 32'h0000145F;
            5'd18: t = 32'h00000A30; 5'd19: t = 32'h00000518; 5'd20: t = 32'h0000028C;
            5'd21: t = 32'h00000146; 5'd22: t = 32'h000000A3; 5'd23: t = 32'h00000051;
            5'd24: t = 32'h00000029; 5'd25: t = 32'h00000014; 5'd26: t = 32'h0000000A;
            5'd27: t = 32'h00000005; 5'd28: t = 32'h00000003; 5'd29: t = 32'h00000001;
            5'd30: t = 32'h00000001;
            default: t = 32'h00000000;
        endcase
        return t;
    endfunction

endpackage

@@ hdl/ddo_front.sv @@
// Front end: takes status reports, computes encoder deltas, map direction and grid steps.
// Depends on ddo_pkg.
module ddo_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  logic [31:0]         i_left_count,
    input  logic [31:0]         i_right_count,
    input  logic [2:0]          i_heading_code,
    input  logic [7:0]          i_moving_flag,
    input  logic [2:0]          i_mission_code,
    input  logic [31:0]         i_mission_count,
    input  logic                i_mode,
    input  logic [2:0]          i_map_dir,
    input  logic [2:0]          i_robot_dir,
    input  logic [23:0]         i_mpt,
    input  logic [23:0]         i_tpt,
    output logic                o_valid,
    output ddo_pkg::t_work      o_work,
    input  logic                i_take
);

    // Two-entry queue between front and back.
    ddo_pkg::t_work r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd, r_wr;
    logic       r_primed;
    logic [31:0] r_last_left, r_last_right, r_last_count;
    logic [7:0]  r_last_moving;
    logic [2:0]  r_last_mission;
    ddo_pkg::t_work w_new;
    logic [1:0]  w_off, w_d;
    logic        w_push, w_pop;

    assign o_full = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_work = r_q[r_rd];
    assign w_push = i_push && !o_full;
    assign w_pop = i_take && o_valid;

    always_comb begin
        w_off = 2'(i_map_dir - i_robot_dir);
        w_d = 2'(i_heading_code - 3'd1) + w_off;
        w_new.prime = !r_primed;
        w_new.dir = (i_heading_code >= 3'd1 && i_heading_code <= 3'd4) ?
                    {1'b0, w_d} + 3'd1 : 3'd0;
        w_new.step = (r_last_moving == 8'd1 && i_moving_flag == 8'd0) ||
                     (i_mission_code == ddo_pkg::MisNext &&
                      (r_last_mission != ddo_pkg::MisNext || r_last_count != i_mission_count));
        w_new.mission = i_mission_code;
        w_new.mode = i_mode;
        w_new.dl = i_left_count - r_last_left;
        w_new.dr = i_right_count - r_last_right;
        w_new.mpt = i_mpt;
        w_new.tpt = i_tpt;
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_new;
        end
        if (!i_rst_n) begin
            r_cnt <= '0; r_rd <= 1'b0; r_wr <= 1'b0; r_primed <= 1'b0;
            r_last_left <= '0; r_last_right <= '0; r_last_count <= '0;
            r_last_moving <= '0; r_last_mission <= ddo_pkg::MisWait;
        end else begin
            if (w_push) begin
                r_wr <= !r_wr;
                r_primed <= 1'b1;
                r_last_left <= i_left_count;
                r_last_right <= i_right_count;
                if (r_primed) begin
                    r_last_moving <= i_moving_flag;
                    r_last_mission <= i_mission_code;
                    r_last_count <= i_mission_count;
                end
            end
            if (w_pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3)
        else $error("queue count out of range");
    a_full_nopush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full && !w_pop |=> o_full)
        else $error("full queue drained without pop");
    a_prime_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_primed |=> r_primed)
        else $error("primed flag dropped");
`endif

endmodule

@@ hdl/ddo_back.sv @@
// Back end: applies turn and travel, runs the iterative CORDIC and keeps the pose.
// Depends on ddo_pkg.
module ddo_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  ddo_pkg::t_work      i_work,
    output logic                o_take,
    output logic                o_empty,
    input  logic                i_pop,
    output logic [15:0]         o_cell_x,
    output logic [15:0]         o_cell_y,
    output logic [31:0]         o_pose_x,
    output logic [31:0]         o_pose_y,
    output logic [31:0]         o_pose_angle
);

    ddo_pkg::t_state r_state, n_state;
    ddo_pkg::t_work  r_w;
    logic [15:0] r_col, r_row;
    logic [31:0] r_px, r_py, r_head;
    logic signed [33:0] r_sum, r_diff;
    logic signed [63:0] r_prod;
    logic [31:0] r_turn, r_trav;
    logic signed [49:0] r_cx, r_cy;
    logic signed [32:0] r_cz;
    logic [ddo_pkg::StepW-1:0] r_i;
    logic r_out_valid;

    logic signed [49:0] w_xs, w_ys;
    logic signed [63:0] w_gain;
    logic [31:0] w_h;

    assign o_empty = !r_out_valid;
    assign o_cell_x = r_col;
    assign o_cell_y = r_row;
    assign o_pose_x = r_px;
    assign o_pose_y = r_py;
    assign o_pose_angle = r_head;
    // A new transaction starts only once the shown result has been taken, since the
    // result ports show the live state registers.
    assign o_take = (r_state == ddo_pkg::S_IDLE) && i_valid && !r_out_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ddo_pkg::S_IDLE: if (o_take) n_state = ddo_pkg::S_MUL;
            ddo_pkg::S_MUL:  n_state = r_w.prime ? ddo_pkg::S_DONE : ddo_pkg::S_TRAV;
            ddo_pkg::S_TRAV: n_state = r_w.mode ? ddo_pkg::S_DONE : ddo_pkg::S_GAIN;
            ddo_pkg::S_GAIN: n_state = ddo_pkg::S_ITER;
            ddo_pkg::S_ITER:
                if (r_i == ddo_pkg::StepW'(ddo_pkg::CordicSteps - 1)) n_state = ddo_pkg::S_DONE;
            ddo_pkg::S_DONE: if (!r_out_valid) n_state = ddo_pkg::S_IDLE;
            default: n_state = ddo_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        w_xs = r_cx >>> r_i;
        w_ys = r_cy >>> r_i;
        w_gain = $signed({{32{r_trav[31]}}, r_trav}) * $signed({32'd0, ddo_pkg::GainQ32});
        w_h = r_head;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ddo_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_col <= '0; r_row <= '0; r_px <= '0; r_py <= '0; r_head <= '0;
        end else begin
            r_state <= n_state;
            if (i_pop && r_out_valid) r_out_valid <= 1'b0;
            case (r_state)
                ddo_pkg::S_IDLE: if (o_take) begin
                    r_w <= i_work;
                    r_sum <= 34'($signed(i_work.dl)) + 34'($signed(i_work.dr));
                    r_diff <= 34'($signed(i_work.dr)) - 34'($signed(i_work.dl));
                end
                ddo_pkg::S_MUL: begin
                    r_prod <= 64'(r_sum) * $signed({40'd0, r_w.mpt});
                    r_turn <= 32'(r_diff[31:0] * {8'd0, r_w.tpt});
                    if (!r_w.prime && r_w.step) begin
                        case (r_w.dir)
                            3'd1: r_row <= r_row + 16'd1;
                            3'd2: r_col <= r_col + 16'd1;
                            3'd3: r_row <= r_row - 16'd1;
                            3'd4: r_col <= r_col - 16'd1;
                            default: ;
                        endcase
                    end
                end
                ddo_pkg::S_TRAV: begin
                    r_trav <= 32'((r_prod + 64'sd65536) >>> 17);
                    if (!r_w.mode) begin
                        r_head <= r_head + r_turn;
                    end else if (r_w.mission >= ddo_pkg::MisTurn &&
                                 r_w.mission <= ddo_pkg::MisRight90) begin
                        r_head <= r_head + r_turn;
                    end else if (r_w.mission == ddo_pkg::MisNext) begin
                        case (r_w.dir)
                            3'd1: r_py <= r_py + 32'((r_prod + 64'sd65536) >>> 17);
                            3'd2: r_px <= r_px + 32'((r_prod + 64'sd65536) >>> 17);
                            3'd3: r_py <= r_py - 32'((r_prod + 64'sd65536) >>> 17);
                            3'd4: r_px <= r_px - 32'((r_prod + 64'sd65536) >>> 17);
                            default: ;
                        endcase
                    end else if (r_w.mission == ddo_pkg::MisWait && r_w.dir != 3'd0) begin
                        r_head <= {2'(3'd2 - r_w.dir), 30'd0};
                    end
                end
                ddo_pkg::S_GAIN: begin
                    r_i <= '0;
                    r_cy <= '0;
                    if (w_h[31] ^ w_h[30]) begin
                        r_cx <= -50'(w_gain >>> 16);
                        r_cz <= 33'($signed(w_h - ddo_pkg::Half));
                    end else begin
                        r_cx <= 50'(w_gain >>> 16);
                        r_cz <= 33'($signed(w_h));
                    end
                end
                ddo_pkg::S_ITER: begin
                    r_i <= r_i + 1'b1;
                    if (!r_cz[32]) begin
                        r_cx <= r_cx - w_ys; r_cy <= r_cy + w_xs;
                        r_cz <= r_cz - $signed({1'b0, ddo_pkg::atan_of(5'(r_i))});
                    end else begin
                        r_cx <= r_cx + w_ys; r_cy <= r_cy - w_xs;
                        r_cz <= r_cz + $signed({1'b0, ddo_pkg::atan_of(5'(r_i))});
                    end
                    if (r_i == ddo_pkg::StepW'(ddo_pkg::CordicSteps - 1)) begin
                        r_px <= r_px + 32'((r_cx + ((!r_cz[32]) ? -w_ys : w_ys)
                                + 50'sd32768) >>> 16);
                        r_py <= r_py + 32'((r_cy + ((!r_cz[32]) ? w_xs : -w_xs)
                                + 50'sd32768) >>> 16);
                    end
                end
                ddo_pkg::S_DONE: if (!r_out_valid) r_out_valid <= 1'b1;
                default: ;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |=> r_state == ddo_pkg::S_MUL)
        else $error("take without start");
    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ddo_pkg::S_DONE && !r_out_valid |=> r_out_valid)
        else $error("result not shown");
    a_iter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ddo_pkg::S_ITER |-> r_i < ddo_pkg::StepW'(ddo_pkg::CordicSteps))
        else $error("CORDIC step out of range");
`endif

endmodule

@@ hdl/diff_drive_odometry_grid_tracker.sv @@
// Top level of the differential drive odometry grid tracker.
// Priming reports pass the multiply state only; mission mode adds the travel state, and free
// mode adds travel, gain and a 24-step CORDIC. A report is taken only while the back end is idle;
// a waiting result holds off the next report, and a two-entry queue holds reports meanwhile.
// Reset is synchronous and active low; it clears pose, grid cell, history and queue, and sets config defaults.
// Depends on ddo_pkg, ddo_front and ddo_back.
module diff_drive_odometry_grid_tracker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] i_left_count,
    input  logic [31:0] i_right_count,
    input  logic [2:0]  i_heading_code,
    input  logic [7:0]  i_moving_flag,
    input  logic [2:0]  i_mission_code,
    input  logic [31:0] i_mission_count,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] o_cell_x,
    output logic [15:0] o_cell_y,
    output logic [31:0] o_pose_x,
    output logic [31:0] o_pose_y,
    output logic [31:0] o_pose_angle,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    // Configuration registers; they are sampled into each transaction as it enters.
    logic        r_mode;
    logic [2:0]  r_map_dir, r_robot_dir;
    logic [23:0] r_mpt, r_tpt;
    logic        w_valid, w_take;
    ddo_pkg::t_work w_work;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0; r_map_dir <= 3'd1; r_robot_dir <= 3'd1;
            r_mpt <= 24'd2698608; r_tpt <= 24'd1309441;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ddo_pkg::RegMode:     r_mode <= i_cfg_data[0];
                ddo_pkg::RegMapDir:   r_map_dir <= i_cfg_data[2:0];
                ddo_pkg::RegRobotDir: r_robot_dir <= i_cfg_data[2:0];
                ddo_pkg::RegMetres:   r_mpt <= i_cfg_data;
                ddo_pkg::RegTurn:     r_tpt <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The front end classifies each transaction; the back end executes it.
    ddo_front u_front (
        .i_clk, .i_rst_n, .i_push(push), .o_full(full),
        .i_left_count, .i_right_count, .i_heading_code, .i_moving_flag,
        .i_mission_code, .i_mission_count,
        .i_mode(r_mode), .i_map_dir(r_map_dir), .i_robot_dir(r_robot_dir),
        .i_mpt(r_mpt), .i_tpt(r_tpt),
        .o_valid(w_valid), .o_work(w_work), .i_take(w_take)
    );

    ddo_back u_back (
        .i_clk, .i_rst_n, .i_valid(w_valid), .i_work(w_work), .o_take(w_take),
        .o_empty(empty), .i_pop(pop),
        .o_cell_x, .o_cell_y, .o_pose_x, .o_pose_y, .o_pose_angle
    );

endmodule
